// ===== rtl/mtpe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtpe_pkg
// Shared types and codes of the mission transfer protocol engine.
// ----------------------------------------------------------------------------
package mtpe_pkg;

  // largest list the engine tracks
  localparam int MAX_ITEMS_DEF = 256;

  // register reset values
  localparam logic [3:0]  MAX_RETRIES_RST = 4'd5;
  localparam logic [15:0] ACK_TICKS_RST   = 16'd1000;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd0;
  localparam logic [1:0] CFG_ACK_TICKS   = 2'd1;
  localparam logic [1:0] CFG_HOME_ALLOW  = 2'd2;

  // incoming events
  typedef enum logic [3:0] {
    A_START_READ  = 4'd0,
    A_START_WRITE = 4'd1,
    A_CLEAR_ALL   = 4'd2,
    A_GUIDED      = 4'd3,
    A_RX_COUNT    = 4'd4,
    A_RX_ITEM     = 4'd5,
    A_RX_REQUEST  = 4'd6,
    A_RX_ACK      = 4'd7,
    A_RX_CURRENT  = 4'd8,
    A_TICK        = 4'd9
  } action_t;

  // message kinds to send
  localparam logic [3:0] SK_NONE     = 4'd0;
  localparam logic [3:0] SK_COUNT    = 4'd1;
  localparam logic [3:0] SK_REQ_LIST = 4'd2;
  localparam logic [3:0] SK_REQ_ITEM = 4'd3;
  localparam logic [3:0] SK_ITEM     = 4'd4;
  localparam logic [3:0] SK_ITEM_INT = 4'd5;
  localparam logic [3:0] SK_ACK      = 4'd6;
  localparam logic [3:0] SK_CLEAR    = 4'd7;
  localparam logic [3:0] SK_GUIDED   = 4'd8;

  // error codes
  localparam logic [2:0] ER_NONE    = 3'd0;
  localparam logic [2:0] ER_VEHICLE = 3'd2;
  localparam logic [2:0] ER_TIMEOUT = 3'd3;
  localparam logic [2:0] ER_RANGE   = 3'd4;
  localparam logic [2:0] ER_MISSING = 3'd5;

  // awaited replies
  localparam logic [2:0] EX_NONE   = 3'd0;
  localparam logic [2:0] EX_COUNT  = 3'd1;
  localparam logic [2:0] EX_ITEM   = 3'd2;
  localparam logic [2:0] EX_REQ    = 3'd3;
  localparam logic [2:0] EX_CLEAR  = 3'd4;
  localparam logic [2:0] EX_GUIDED = 3'd5;

  // transaction kinds
  localparam logic [1:0] TK_NONE  = 2'd0;
  localparam logic [1:0] TK_READ  = 2'd1;
  localparam logic [1:0] TK_WRITE = 2'd2;
  localparam logic [1:0] TK_CLEAR = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BIT,
    ST_SREAD,
    ST_SCHK,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/mission_transfer_protocol_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mission_transfer_protocol_engine
// Ground-side mission upload, download and clear sequencer with retry and
// timeout handling; pending sequence maps kept in word memories.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, action .. list_type    | request in
//  out     | out_valid/out_ready, send_kind .. busy_res| result out
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register write
//
// Most requests pass through accept, execute and result load. A received item,
// a request or a write timeout adds a memory read step (ST_BIT); a lowest-pending
// search adds a read and a check step (ST_SREAD, ST_SCHK) per 32-entry word
// scanned. No clearing pass: a fill count and per-word valid flags mark the maps.
// A stalled result holds the next request at its result load, and in_ready
// stays low until that load happens.
// Reset is synchronous and returns all control state to idle.
module mission_transfer_protocol_engine #(
  parameter int MAX_ITEMS = mtpe_pkg::MAX_ITEMS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         action,
  input  wire logic [8:0]         item_count,
  input  wire logic [15:0]        seq,
  input  wire logic               request_int,
  input  wire logic [3:0]         ack_result,
  input  wire logic [1:0]         list_type,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              send_kind,
  output logic [15:0]             send_seq,
  output logic [1:0]              send_type,
  output logic [2:0]              error_code,
  output logic                    done_res,
  output logic                    success,
  output logic [1:0]              finished_kind,
  output logic                    item_accepted,
  output logic                    home_update,
  output logic                    current_changed,
  output logic signed [16:0]      current_index,
  output logic                    busy_res,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import mtpe_pkg::*;

  localparam int WORDS = (MAX_ITEMS + 31) / 32;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(MAX_ITEMS + 1);

  // configuration
  logic [3:0]  max_retries;
  logic [15:0] ack_ticks;
  logic        home_allow;

  // latched request
  action_t     l_act;
  logic [CW-1:0] l_cnt;
  logic [15:0] l_sq;
  logic        l_rint;
  logic [3:0]  l_ack;
  logic [1:0]  l_mt;

  // engine state
  state_t      state, state_next;
  logic [1:0]  kind;
  logic [2:0]  expr;
  logic [4:0]  retry;
  logic [15:0] tcnt;
  logic [CW-1:0] rfill, wfill, rrem, wrem, wtotal;
  logic signed [16:0] cur;
  logic [1:0]  atype;
  logic [WORDS-1:0] rvalid, wvalid;
  logic [WAW-1:0] scan_w;
  logic        l_home;

  // working result
  logic [3:0]  rs_kind;
  logic [15:0] rs_seq;
  logic [1:0]  rs_type;
  logic [2:0]  rs_err;
  logic        rs_done, rs_ok, rs_acc, rs_home, rs_chg;
  logic [1:0]  rs_fkind;

  // taken-bit memories, one bit per sequence number
  logic [31:0] rmem [WORDS];
  logic [31:0] wmem [WORDS];
  logic [31:0] rd_r, rd_w;
  logic [WAW-1:0] mem_addr;
  logic        r_we, w_we;
  logic [31:0] wdata;

  // pending bits of one map word
  function automatic logic [31:0] pend_word(input logic [31:0] taken, input logic vld,
                                            input logic [WAW-1:0] w,
                                            input logic [CW-1:0] fill);
    logic [31:0] pw;
    for (int b = 0; b < 32; b++) begin
      pw[b] = ((32'(w) * 32 + 32'(b)) < 32'(fill)) && !(vld && taken[b]);
    end
    return pw;
  endfunction

  // decisions
  logic        home_ok, tick_fire, retry_ok;
  logic        exec_bit, exec_scan;
  logic [WAW-1:0] bit_w;
  logic [4:0]  bit_p;
  logic        bit_pend, bit_scan;
  logic [31:0] scan_pw;
  logic        scan_hit;
  logic [4:0]  scan_pos;
  logic        in_acc, out_load;

  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  always_comb begin
    home_ok   = home_allow && (l_sq == 16'd0);
    tick_fire = (l_act == A_TICK) && (tcnt == 16'd1) && (expr != EX_NONE);
    retry_ok  = retry <= {1'b0, max_retries};
    exec_bit  = ((l_act == A_RX_ITEM) && ((expr == EX_ITEM) || home_ok)) ||
                ((l_act == A_RX_REQUEST) && (expr == EX_REQ) &&
                 (32'(l_sq) < 32'(wtotal))) ||
                (tick_fire && (expr == EX_REQ) && (wrem != '0));
    exec_scan = tick_fire && (expr == EX_ITEM) && retry_ok && (rrem != '0);
    if (l_act == A_TICK) begin
      bit_w = '0;
      bit_p = 5'd0;
    end else begin
      bit_w = l_sq[WAW+4:5];
      bit_p = l_sq[4:0];
    end
    if (l_act == A_RX_ITEM) begin
      bit_pend = (32'(l_sq) < 32'(rfill)) && !(rvalid[bit_w] && rd_r[bit_p]);
      wdata    = (rvalid[bit_w] ? rd_r : 32'd0) | (32'd1 << bit_p);
    end else begin
      bit_pend = (32'(l_sq) < 32'(wfill)) && !(wvalid[bit_w] && rd_w[bit_p]);
      wdata    = (wvalid[bit_w] ? rd_w : 32'd0) | (32'd1 << bit_p);
    end
    bit_scan = (l_act == A_RX_ITEM) && bit_pend && (rrem != CW'(1));
    r_we = (state == ST_BIT) && (l_act == A_RX_ITEM) && bit_pend;
    w_we = (state == ST_BIT) && (l_act == A_RX_REQUEST) && bit_pend;
    scan_pw  = pend_word(rd_r, rvalid[scan_w], scan_w, rfill);
    scan_hit = |scan_pw;
    scan_pos = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (scan_pw[b]) scan_pos = 5'(b);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) state_next = ST_EXEC;
      ST_EXEC: begin
        if (exec_bit)       state_next = ST_BIT;
        else if (exec_scan) state_next = ST_SREAD;
        else                state_next = ST_OUT;
      end
      ST_BIT:   state_next = bit_scan ? ST_SREAD : ST_OUT;
      ST_SREAD: state_next = ST_SCHK;
      ST_SCHK: begin
        if (scan_hit || (32'(scan_w) == WORDS - 1)) state_next = ST_OUT;
        else                                        state_next = ST_SREAD;
      end
      ST_OUT:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // handshake and memory address
  always_comb begin
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_EXEC:  mem_addr = bit_w;
      ST_SREAD: mem_addr = scan_w;
      default:  mem_addr = bit_w;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // map memories
  always_ff @(posedge clk) begin
    if (r_we) rmem[bit_w] <= wdata;
    if (w_we) wmem[bit_w] <= wdata;
    rd_r <= rmem[mem_addr];
    rd_w <= wmem[mem_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      send_kind       <= rs_kind;
      send_seq        <= rs_seq;
      send_type       <= rs_type;
      error_code      <= rs_err;
      done_res        <= rs_done;
      success         <= rs_ok;
      finished_kind   <= rs_fkind;
      item_accepted   <= rs_acc;
      home_update     <= rs_home;
      current_changed <= rs_chg;
      current_index   <= cur;
      busy_res        <= (kind != TK_NONE);
    end
  end

  // engine datapath
  always_ff @(posedge clk) begin : dp
    logic       fin;
    logic       fin_ok;
    logic       arm_en;
    logic [2:0] arm_exp;
    fin = 1'b0;
    fin_ok = 1'b0;
    arm_en = 1'b0;
    arm_exp = EX_NONE;
    if (rst) begin
      max_retries <= MAX_RETRIES_RST;
      ack_ticks   <= ACK_TICKS_RST;
      home_allow  <= 1'b0;
      kind   <= TK_NONE;
      expr   <= EX_NONE;
      retry  <= '0;
      tcnt   <= '0;
      rfill  <= '0;
      wfill  <= '0;
      rrem   <= '0;
      wrem   <= '0;
      wtotal <= '0;
      cur    <= -17'sd1;
      atype  <= '0;
      rvalid <= '0;
      wvalid <= '0;
      scan_w <= '0;
    end else begin
      // register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_RETRIES: max_retries <= cfg_data[3:0];
          CFG_ACK_TICKS:   ack_ticks <= cfg_data;
          CFG_HOME_ALLOW:  home_allow <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            l_act  <= action_t'(action);
            l_cnt  <= (32'(item_count) > MAX_ITEMS) ? CW'(MAX_ITEMS) : CW'(item_count);
            l_sq   <= seq;
            l_rint <= request_int;
            l_ack  <= ack_result;
            l_mt   <= (list_type == 2'd3) ? 2'd0 : list_type;
            l_home <= 1'b0;
            rs_kind <= SK_NONE;
            rs_seq  <= '0;
            rs_type <= '0;
            rs_err  <= ER_NONE;
            rs_done <= 1'b0;
            rs_ok   <= 1'b0;
            rs_fkind <= TK_NONE;
            rs_acc  <= 1'b0;
            rs_home <= 1'b0;
            rs_chg  <= 1'b0;
          end
        end
        ST_EXEC: begin
          scan_w <= '0;
          case (l_act)
            A_START_READ: begin
              if (kind == TK_NONE) begin
                atype <= l_mt;
                retry <= '0;
                kind  <= TK_READ;
                rfill <= '0;
                rrem  <= '0;
                rs_kind <= SK_REQ_LIST;
                rs_type <= l_mt;
                arm_en = 1'b1;
                arm_exp = EX_COUNT;
              end
            end
            A_START_WRITE: begin
              if (kind == TK_NONE && l_cnt != '0) begin
                atype  <= l_mt;
                wtotal <= l_cnt;
                wfill  <= l_cnt;
                wvalid <= '0;
                wrem   <= l_cnt;
                kind   <= TK_WRITE;
                retry  <= '0;
                rs_kind <= SK_COUNT;
                rs_seq  <= 16'(l_cnt);
                rs_type <= l_mt;
                arm_en = 1'b1;
                arm_exp = EX_REQ;
                if (cur != -17'sd1) rs_chg <= 1'b1;
                cur <= -17'sd1;
              end
            end
            A_CLEAR_ALL: begin
              if (kind == TK_NONE) begin
                if (cur != -17'sd1) rs_chg <= 1'b1;
                cur   <= -17'sd1;
                kind  <= TK_CLEAR;
                retry <= '0;
                atype <= '0;
                rs_kind <= SK_CLEAR;
                arm_en = 1'b1;
                arm_exp = EX_CLEAR;
              end
            end
            A_GUIDED: begin
              if (kind == TK_NONE) begin
                kind <= TK_WRITE;
                rs_kind <= SK_GUIDED;
                arm_en = 1'b1;
                arm_exp = EX_GUIDED;
              end
            end
            A_RX_COUNT: begin
              if (expr == EX_COUNT) begin
                expr  <= EX_NONE;
                tcnt  <= '0;
                retry <= '0;
                if (l_cnt == '0) begin
                  rs_kind <= SK_ACK;
                  rs_type <= atype;
                  fin = 1'b1;
                  fin_ok = 1'b1;
                end else begin
                  // fresh map: lowest pending is entry zero
                  rfill  <= l_cnt;
                  rvalid <= '0;
                  rrem   <= l_cnt;
                  rs_kind <= SK_REQ_ITEM;
                  rs_type <= atype;
                  arm_en = 1'b1;
                  arm_exp = EX_ITEM;
                end
              end
            end
            A_RX_ITEM: begin
              if (expr == EX_ITEM) begin
                expr <= EX_NONE;
                tcnt <= '0;
              end else if (home_ok) begin
                l_home <= 1'b1;
              end
            end
            A_RX_REQUEST: begin
              if (expr == EX_REQ) begin
                expr <= EX_NONE;
                tcnt <= '0;
                if (32'(l_sq) >= 32'(wtotal)) begin
                  rs_err <= ER_RANGE;
                  fin = 1'b1;
                end else begin
                  rs_kind <= l_rint ? SK_ITEM_INT : SK_ITEM;
                  rs_seq  <= l_sq;
                  rs_type <= atype;
                  arm_en = 1'b1;
                  arm_exp = EX_REQ;
                end
              end
            end
            A_RX_ACK: begin
              expr <= EX_NONE;
              tcnt <= '0;
              case (expr)
                EX_NONE: rs_err <= ER_VEHICLE;
                EX_REQ: begin
                  fin = 1'b1;
                  if (l_ack != 4'd0)    rs_err <= ER_VEHICLE;
                  else if (wrem == '0)  fin_ok = 1'b1;
                  else                  rs_err <= ER_MISSING;
                end
                EX_CLEAR, EX_GUIDED: begin
                  fin = 1'b1;
                  if (l_ack != 4'd0) rs_err <= ER_VEHICLE;
                  else               fin_ok = 1'b1;
                end
                default: begin
                  fin = 1'b1;
                  rs_err <= ER_VEHICLE;
                end
              endcase
            end
            A_RX_CURRENT: begin
              if ($signed({1'b0, l_sq}) != cur) begin
                cur <= $signed({1'b0, l_sq});
                rs_chg <= 1'b1;
              end
            end
            A_TICK: begin
              if (tcnt != '0) tcnt <= tcnt - 16'd1;
              if (tick_fire) begin
                case (expr)
                  EX_COUNT: begin
                    if (!retry_ok) begin
                      rs_err <= ER_VEHICLE;
                      fin = 1'b1;
                    end else begin
                      retry <= retry + 5'd1;
                      rfill <= '0;
                      rrem  <= '0;
                      rs_kind <= SK_REQ_LIST;
                      rs_type <= atype;
                      arm_en = 1'b1;
                      arm_exp = EX_COUNT;
                    end
                  end
                  EX_ITEM: begin
                    if (!retry_ok) begin
                      rs_err <= ER_VEHICLE;
                      fin = 1'b1;
                    end else begin
                      retry <= retry + 5'd1;
                    end
                  end
                  EX_REQ: begin
                    if (wrem == '0) begin
                      rs_err <= ER_VEHICLE;
                      fin = 1'b1;
                    end
                  end
                  EX_CLEAR: begin
                    if (!retry_ok) begin
                      rs_err <= ER_VEHICLE;
                      fin = 1'b1;
                    end else begin
                      retry <= retry + 5'd1;
                      rs_kind <= SK_CLEAR;
                      arm_en = 1'b1;
                      arm_exp = EX_CLEAR;
                    end
                  end
                  default: begin
                    expr <= EX_NONE;
                    rs_err <= ER_TIMEOUT;
                    fin = 1'b1;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
        ST_BIT: begin
          case (l_act)
            A_RX_ITEM: begin
              if (bit_pend) begin
                rvalid[bit_w] <= 1'b1;
                rrem    <= rrem - CW'(1);
                rs_acc  <= 1'b1;
                rs_home <= l_home;
                retry   <= '0;
                if (rrem == CW'(1)) begin
                  rs_kind <= SK_ACK;
                  rs_type <= atype;
                  fin = 1'b1;
                  fin_ok = 1'b1;
                end
              end else begin
                arm_en = 1'b1;
                arm_exp = EX_ITEM;
              end
            end
            A_RX_REQUEST: begin
              if (bit_pend) begin
                wvalid[bit_w] <= 1'b1;
                wrem <= wrem - CW'(1);
              end
            end
            default: begin
              // write timeout: only a lost count is retried
              if (bit_pend) begin
                if (!retry_ok) begin
                  rs_err <= ER_VEHICLE;
                  fin = 1'b1;
                end else begin
                  retry <= retry + 5'd1;
                  rs_kind <= SK_COUNT;
                  rs_seq  <= 16'(wtotal);
                  rs_type <= atype;
                  arm_en = 1'b1;
                  arm_exp = EX_REQ;
                end
              end else begin
                expr <= EX_NONE;
                rs_err <= ER_TIMEOUT;
                fin = 1'b1;
              end
            end
          endcase
        end
        ST_SREAD: ;
        ST_SCHK: begin
          if (scan_hit) begin
            rs_kind <= SK_REQ_ITEM;
            rs_seq  <= 16'({scan_w, scan_pos});
            rs_type <= atype;
            arm_en = 1'b1;
            arm_exp = EX_ITEM;
          end else begin
            scan_w <= scan_w + WAW'(1);
          end
        end
        ST_OUT: ;
        default: ;
      endcase
      // arm the reply timer
      if (arm_en) begin
        expr <= arm_exp;
        tcnt <= (ack_ticks == 16'd0) ? 16'd1 : ack_ticks;
      end
      // close the transaction
      if (fin) begin
        rs_done  <= (kind != TK_NONE);
        rs_ok    <= (kind != TK_NONE) && fin_ok;
        rs_fkind <= kind;
        rfill <= '0;
        wfill <= '0;
        rrem  <= '0;
        wrem  <= '0;
        if (kind == TK_WRITE) wtotal <= '0;
        kind <= TK_NONE;
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/mission_transfer_protocol_engine_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mission_transfer_protocol_engine_test
// Drives mission download, upload, clear and guided exchanges into the engine,
// mixed with timer ticks and malformed messages, under several register
// settings and random stalls on both sides. Every result is compared with an
// independent model of the engine kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module mission_transfer_protocol_engine_test;
  import mtpe_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] sq;
    logic [1:0]  typ;
    logic [2:0]  err;
    logic        done;
    logic        ok;
    logic [1:0]  fkind;
    logic        acc;
    logic        home;
    logic        chg;
    logic [16:0] idx;
    logic        busy;
  } mission_result_t;

  // model of the engine plus the queue of results still owed
  class mission_scoreboard;
    bit [3:0]        max_retries;
    bit [15:0]       ack_ticks;
    bit              home_ok;
    bit [1:0]        txn;
    bit [2:0]        awaiting;
    int unsigned     retries;
    bit [15:0]       tmo;
    bit [255:0]      rd_pend;
    bit [255:0]      wr_pend;
    int unsigned     rd_left;
    int unsigned     wr_left;
    int unsigned     wr_total;
    int              cur;
    bit [1:0]        act_type;
    mission_result_t r;
    mission_result_t owed[$];
    int              errors;

    function void reset_state();
      max_retries = MAX_RETRIES_RST;
      ack_ticks = ACK_TICKS_RST;
      home_ok = 0;
      txn = TK_NONE;
      awaiting = EX_NONE;
      retries = 0;
      tmo = 0;
      rd_pend = '0;
      wr_pend = '0;
      rd_left = 0;
      wr_left = 0;
      wr_total = 0;
      cur = -1;
      act_type = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_MAX_RETRIES: max_retries = data[3:0];
        CFG_ACK_TICKS:   ack_ticks = data;
        CFG_HOME_ALLOW:  home_ok = data[0];
        default: ;
      endcase
    endfunction

    function int lowest(bit [255:0] m);
      for (int i = 0; i < 256; i++)
        if (m[i]) return i;
      return -1;
    endfunction

    function void send(logic [3:0] k, int unsigned s, logic [1:0] t);
      r.kind = k;
      r.sq = s[15:0];
      r.typ = t;
    endfunction

    function void arm(logic [2:0] e);
      awaiting = e;
      tmo = (ack_ticks != 0) ? ack_ticks : 16'd1;
    endfunction

    function void disarm();
      awaiting = EX_NONE;
      tmo = 0;
    endfunction

    function void finish(bit good);
      r.done = (txn != TK_NONE);
      r.ok = r.done && good;
      r.fkind = txn;
      rd_pend = '0;
      wr_pend = '0;
      rd_left = 0;
      wr_left = 0;
      if (txn == TK_WRITE) wr_total = 0;
      txn = TK_NONE;
    endfunction

    function void fail(logic [2:0] code);
      r.err = code;
      finish(0);
    endfunction

    function void ask_for_list();
      rd_pend = '0;
      rd_left = 0;
      send(SK_REQ_LIST, 0, act_type);
      arm(EX_COUNT);
    endfunction

    function void request_next();
      int i;
      i = lowest(rd_pend);
      if (rd_left == 0 || i < 0) return;
      send(SK_REQ_ITEM, i, act_type);
      arm(EX_ITEM);
    endfunction

    function void read_complete();
      send(SK_ACK, 0, act_type);
      finish(1);
    endfunction

    function void unknown_index();
      if (cur != -1) r.chg = 1;
      cur = -1;
    endfunction

    // retry or give up once the reply wait runs out
    function void on_timeout();
      int i;
      case (awaiting)
        EX_COUNT: begin
          if (retries > max_retries) fail(ER_VEHICLE);
          else begin
            retries++;
            ask_for_list();
          end
        end
        EX_ITEM: begin
          if (retries > max_retries) fail(ER_VEHICLE);
          else begin
            retries++;
            request_next();
          end
        end
        EX_REQ: begin
          i = lowest(wr_pend);
          if (wr_left == 0 || i < 0) fail(ER_VEHICLE);
          else if (i == 0) begin
            if (retries > max_retries) fail(ER_VEHICLE);
            else begin
              retries++;
              send(SK_COUNT, wr_total, act_type);
              arm(EX_REQ);
            end
          end else begin
            awaiting = EX_NONE;
            fail(ER_TIMEOUT);
          end
        end
        EX_CLEAR: begin
          if (retries > max_retries) fail(ER_VEHICLE);
          else begin
            retries++;
            send(SK_CLEAR, 0, 0);
            arm(EX_CLEAR);
          end
        end
        default: begin
          awaiting = EX_NONE;
          fail(ER_TIMEOUT);
        end
      endcase
    endfunction

    // accepted request: advance the model and queue the expected result
    function void note(logic [3:0] act, logic [8:0] count, logic [15:0] s, logic rint,
                       logic [3:0] ackres, logic [1:0] mt);
      int unsigned cnt;
      logic [1:0]  mtype;
      logic [2:0]  saved;
      bit          home;
      cnt = (count > 256) ? 256 : count;
      mtype = (mt == 2'd3) ? 2'd0 : mt;
      r = '0;
      case (act)
        A_START_READ: begin
          if (txn == TK_NONE) begin
            act_type = mtype;
            retries = 0;
            txn = TK_READ;
            ask_for_list();
          end
        end
        A_START_WRITE: begin
          if (txn == TK_NONE && cnt != 0) begin
            act_type = mtype;
            wr_total = cnt;
            wr_pend = '0;
            for (int i = 0; i < cnt; i++) wr_pend[i] = 1;
            wr_left = cnt;
            txn = TK_WRITE;
            retries = 0;
            send(SK_COUNT, cnt, act_type);
            arm(EX_REQ);
            unknown_index();
          end
        end
        A_CLEAR_ALL: begin
          if (txn == TK_NONE) begin
            unknown_index();
            txn = TK_CLEAR;
            retries = 0;
            act_type = 0;
            send(SK_CLEAR, 0, 0);
            arm(EX_CLEAR);
          end
        end
        A_GUIDED: begin
          if (txn == TK_NONE) begin
            txn = TK_WRITE;
            send(SK_GUIDED, 0, 0);
            arm(EX_GUIDED);
          end
        end
        A_RX_COUNT: begin
          if (awaiting == EX_COUNT) begin
            disarm();
            retries = 0;
            if (cnt == 0) read_complete();
            else begin
              for (int i = 0; i < cnt; i++) rd_pend[i] = 1;
              rd_left = cnt;
              request_next();
            end
          end
        end
        A_RX_ITEM: begin
          home = 0;
          if (awaiting == EX_ITEM || (home_ok && s == 0)) begin
            if (awaiting == EX_ITEM) disarm();
            else home = 1;
            if (s < 256 && rd_pend[s[7:0]]) begin
              rd_pend[s[7:0]] = 0;
              if (rd_left != 0) rd_left--;
              r.acc = 1;
              r.home = home;
              retries = 0;
              if (rd_left == 0) read_complete();
              else request_next();
            end else
              arm(EX_ITEM);
          end
        end
        A_RX_REQUEST: begin
          if (awaiting == EX_REQ) begin
            disarm();
            if (s >= wr_total) fail(ER_RANGE);
            else begin
              if (s < 256 && wr_pend[s[7:0]]) begin
                wr_pend[s[7:0]] = 0;
                if (wr_left != 0) wr_left--;
              end
              send(rint ? SK_ITEM_INT : SK_ITEM, s, act_type);
              arm(EX_REQ);
            end
          end
        end
        A_RX_ACK: begin
          saved = awaiting;
          disarm();
          case (saved)
            EX_NONE: r.err = ER_VEHICLE;
            EX_REQ: begin
              if (ackres != 0) fail(ER_VEHICLE);
              else if (wr_left == 0) finish(1);
              else fail(ER_MISSING);
            end
            EX_CLEAR, EX_GUIDED: begin
              if (ackres != 0) fail(ER_VEHICLE);
              else finish(1);
            end
            default: fail(ER_VEHICLE);
          endcase
        end
        A_RX_CURRENT: begin
          if (int'(s) != cur) begin
            cur = s;
            r.chg = 1;
          end
        end
        A_TICK: begin
          if (tmo != 0) begin
            tmo--;
            if (tmo == 0 && awaiting != EX_NONE) on_timeout();
          end
        end
        default: ;
      endcase
      r.idx = cur[16:0];
      r.busy = (txn != TK_NONE);
      owed.push_back(r);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    // compare one result against the oldest owed one
    function void check(mission_result_t got);
      mission_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual %h", $time, got);
        return;
      end
      want = owed.pop_front();
      cmp("send_kind", want.kind, got.kind);
      cmp("send_seq", want.sq, got.sq);
      cmp("send_type", want.typ, got.typ);
      cmp("error_code", want.err, got.err);
      cmp("done_res", want.done, got.done);
      cmp("success", want.ok, got.ok);
      cmp("finished_kind", want.fkind, got.fkind);
      cmp("item_accepted", want.acc, got.acc);
      cmp("home_update", want.home, got.home);
      cmp("current_changed", want.chg, got.chg);
      cmp("current_index", want.idx, got.idx);
      cmp("busy_res", want.busy, got.busy);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [3:0]  action = 0;
  logic [8:0]  item_count = 0;
  logic [15:0] seq = 0;
  logic        request_int = 0;
  logic [3:0]  ack_result = 0;
  logic [1:0]  list_type = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [3:0]  send_kind;
  logic [15:0] send_seq;
  logic [1:0]  send_type;
  logic [2:0]  error_code;
  logic        done_res;
  logic        success;
  logic [1:0]  finished_kind;
  logic        item_accepted;
  logic        home_update;
  logic        current_changed;
  logic signed [16:0] current_index;
  logic        busy_res;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;

  mission_scoreboard sb = new();
  int unsigned send_idle;
  int unsigned recv_idle;
  bit          hold_go;
  int unsigned hold_left;
  int unsigned cycles;

  mission_transfer_protocol_engine i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .item_count(item_count), .seq(seq),
    .request_int(request_int), .ack_result(ack_result), .list_type(list_type),
    .out_valid(out_valid), .out_ready(out_ready),
    .send_kind(send_kind), .send_seq(send_seq), .send_type(send_type),
    .error_code(error_code), .done_res(done_res), .success(success),
    .finished_kind(finished_kind), .item_accepted(item_accepted),
    .home_update(home_update), .current_changed(current_changed),
    .current_index(current_index), .busy_res(busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mission_transfer_protocol_engine_test: errors");
      $finish;
    end
  end

  // result side: check, then choose ready for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check({send_kind, send_seq, send_type, error_code, done_res, success,
                finished_kind, item_accepted, home_update, current_changed,
                current_index, busy_res});
    if (hold_go) begin
      hold_go = 0;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 0;
    end else
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // offer one request and wait until it is taken
  task automatic push(logic [3:0] act, logic [8:0] cnt, logic [15:0] s, logic rint,
                      logic [3:0] ackres, logic [1:0] mt);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    item_count <= cnt;
    seq <= s;
    request_int <= rint;
    ack_result <= ackres;
    list_type <= mt;
    do @(posedge clk); while (!in_ready);
    sb.note(act, cnt, s, rint, ackres, mt);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // wait for every owed result, then let the engine settle
  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (sb.owed.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [8:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 9'd256;
    if (roll < 5) return 9'($urandom_range(257, 511));
    return 9'($urandom_range(0, 6));
  endfunction

  // one random request, mostly the reply the engine is waiting for
  task automatic random_item();
    int unsigned roll;
    int          low;
    roll = $urandom_range(0, 99);
    if (roll < 8)
      push(4'($urandom_range(0, 15)), 9'($urandom), 16'($urandom), 1'($urandom),
           4'($urandom), 2'($urandom));
    else if (roll < 35)
      push(A_TICK, 0, 0, 0, 0, 0);
    else if (roll < 40)
      push(A_RX_CURRENT, 0, 16'($urandom_range(0, 4)), 0, 0, 0);
    else begin
      case (sb.awaiting)
        EX_NONE:
          push(4'($urandom_range(0, 3)), pick_count(), 16'($urandom_range(0, 3)), 0, 0,
               2'($urandom));
        EX_COUNT:
          push(A_RX_COUNT, pick_count(), 0, 0, 0, 0);
        EX_ITEM: begin
          low = sb.lowest(sb.rd_pend);
          if ($urandom_range(0, 9) < 8 && low >= 0)
            push(A_RX_ITEM, 0, 16'(low), 0, 0, 0);
          else
            push(A_RX_ITEM, 0, 16'($urandom_range(0, 8)), 0, 0, 0);
        end
        EX_REQ: begin
          if (sb.wr_left == 0 || $urandom_range(0, 19) == 0)
            push(A_RX_ACK, 0, 0, 0, ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd0, 0);
          else if ($urandom_range(0, 19) == 0)
            push(A_RX_REQUEST, 0, 16'(sb.wr_total), 1'($urandom), 0, 0);
          else begin
            low = sb.lowest(sb.wr_pend);
            push(A_RX_REQUEST, 0,
                 ($urandom_range(0, 3) != 0 && low >= 0) ? 16'(low)
                   : 16'($urandom_range(0, sb.wr_total - 1)),
                 1'($urandom), 0, 0);
          end
        end
        default:
          push(A_RX_ACK, 0, 0, 0, ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd0, 0);
      endcase
    end
  endtask

  initial begin
    logic [3:0]  retry_set[6];
    logic [15:0] tick_set[6];
    sb.reset_state();
    send_idle = 0;
    recv_idle = 0;
    hold_go = 0;
    hold_left = 0;
    cycles = 0;
    retry_set = '{4'd0, 4'd15, 4'd5, 4'd2, 4'd1, 4'd3};
    tick_set = '{16'd1, 16'd3, 16'd65535, 16'd0, 16'd2, 16'd4};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: idle oddities, index tracking, upload edges, download, clear, guided
    push(A_TICK, 0, 0, 0, 0, 0);
    push(A_RX_ACK, 0, 0, 0, 0, 0);
    push(A_RX_CURRENT, 0, 16'd5, 0, 0, 0);
    push(A_RX_CURRENT, 0, 16'd5, 0, 0, 0);
    push(A_RX_CURRENT, 0, 16'hFFFF, 0, 0, 0);
    push(A_START_WRITE, 9'd0, 0, 0, 0, 2'd1);
    push(A_START_WRITE, 9'd300, 0, 0, 0, 2'd3);
    push(A_START_READ, 0, 0, 0, 0, 2'd2);
    push(A_RX_REQUEST, 0, 16'd0, 1, 0, 0);
    push(A_RX_REQUEST, 0, 16'd255, 0, 0, 0);
    push(A_RX_REQUEST, 0, 16'd256, 0, 0, 0);
    push(A_START_READ, 0, 0, 0, 0, 2'd2);
    push(A_RX_COUNT, 9'd2, 0, 0, 0, 0);
    push(A_RX_ITEM, 0, 16'd1, 0, 0, 0);
    push(A_RX_ITEM, 0, 16'd0, 0, 0, 0);
    push(A_CLEAR_ALL, 0, 0, 0, 0, 0);
    push(A_RX_ACK, 0, 0, 0, 4'd15, 0);
    push(A_GUIDED, 0, 0, 0, 0, 0);
    push(A_RX_ACK, 0, 0, 0, 0, 0);
    push(4'd15, 9'h1FF, 16'hFFFF, 1, 4'hF, 2'd3);
    push(A_START_WRITE, 9'd1, 0, 0, 0, 2'd1);
    push(A_RX_REQUEST, 0, 16'd0, 0, 0, 0);
    push(A_RX_ACK, 0, 0, 0, 0, 0);

    // random phases under changing registers and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_MAX_RETRIES, {12'd0, retry_set[ph]});
      write_reg(CFG_ACK_TICKS, tick_set[ph]);
      write_reg(CFG_HOME_ALLOW, {15'd0, ph[0]});
      case (ph % 3)
        0: begin
          send_idle = 20;
          recv_idle = 50;
        end
        1: begin
          send_idle = 50;
          recv_idle = 20;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 20) hold_go = 1;
        random_item();
      end
    end
    drain();

    if (sb.errors == 0)
      $display("mission_transfer_protocol_engine_test: clean");
    else
      $display("mission_transfer_protocol_engine_test: errors");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/mtpe_pkg.sv
rtl/mission_transfer_protocol_engine.sv
test/mission_transfer_protocol_engine_test.sv
